>>> hw/rtl/fgn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared widths, constants and register map of the frame gain normaliser.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int SAMPLE_W = 24;            // signed Q2.22 samples
  localparam int CLIP_W   = 23;            // unsigned Q1.22 limit
  localparam int RATE_W   = 13;            // unsigned Q0.16 coefficient
  localparam int GAIN_W   = 24;            // unsigned Q8.16 gain
  localparam int MAG_W    = 31;            // scaled magnitude before clipping
  localparam int MUL_N    = 24;            // multiplier steps, one bit each
  localparam int MEAN_W   = 23;            // frame mean, Q1.22, below 2.0

  localparam int FRAME_MAX_DEF = 1024;

  localparam logic [GAIN_W-1:0] GAIN_ONE   = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] GAIN_FLOOR = GAIN_W'(66);
  localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
  localparam logic [MEAN_W-1:0] UNIT_Q22   = MEAN_W'(4194304);
  localparam logic [CLIP_W-1:0] CLIP_RST   = CLIP_W'(4194304);
  localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(655);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_CLIP_LIMIT = 1'b0,
    REG_GAIN_RATE  = 1'b1
  } reg_idx_t;

endpackage : fgn_pkg
`default_nettype wire

>>> hw/rtl/fgn_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_in_if / fgn_out_if
// Valid/ready channels carrying sample transactions in and out.
// ----------------------------------------------------------------------------
interface fgn_in_if;
  import fgn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       frame_last;

  modport source (output valid, output sample_in, output frame_last, input ready);
  modport sink   (input valid, input sample_in, input frame_last, output ready);
endinterface : fgn_in_if

interface fgn_out_if;
  import fgn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       was_clipped;
  logic                       frame_end;

  modport source (output valid, output sample_out, output was_clipped,
                  output frame_end, input ready);
  modport sink   (input valid, input sample_out, input was_clipped,
                  input frame_end, output ready);
endinterface : fgn_out_if
`default_nettype wire

>>> hw/rtl/fgn_serdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fgn_serdiv
// Restoring divider, one quotient bit per cycle. The caller supplies the
// upper dividend part already reduced below the divisor.
// ----------------------------------------------------------------------------
module fgn_serdiv #(
  parameter int DIV_W = fgn_pkg::MAG_W,
  parameter int Q_W   = fgn_pkg::GAIN_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] divisor,
  input  wire logic [DIV_W-1:0] rem_init,
  input  wire logic [Q_W-1:0]   dividend_lo,
  output logic                  busy,
  output logic                  done,
  output logic [Q_W-1:0]        quotient
);
  import fgn_pkg::*;

  localparam int CNT_W = $clog2(Q_W + 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r, dvsr_r;
  logic [Q_W-1:0]   lo_r, q_r;
  logic [DIV_W:0]   shifted, trial;
  logic             ge;

  assign shifted = {rem_r, lo_r[Q_W-1]};
  assign ge      = shifted >= {1'b0, dvsr_r};
  assign trial   = shifted - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem_init;
      dvsr_r <= divisor;
      lo_r   <= dividend_lo;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      lo_r  <= {lo_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule : fgn_serdiv
`default_nettype wire

>>> hw/rtl/frame_gain_normalizer_unit.sv
`default_nettype none
// Sequence: serial multiply, then clip check; a clip adds the gain divide unless
//   the gain would overflow, and a frame end the mean divide plus serial multiply for the gain step.
// Throughput: one transaction in flight; the next is taken once the result is
//   in the output register, so the pace per sample is set by the
//   bit-serial multiplier and the shared one-bit-per-cycle divider.
// Reset: synchronous, active low; gain returns to 1.0, sum and count to zero.
// ----------------------------------------------------------------------------
// frame_gain_normalizer_unit
// Automatic gain control with clipping: serial scale, clip, frame-mean update.
// ----------------------------------------------------------------------------
module frame_gain_normalizer_unit #(
  parameter int FRAME_MAX = fgn_pkg::FRAME_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  fgn_in_if.sink                             in_ch,
  fgn_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fgn_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fgn_pkg::PDATA_W-1:0]   pwdata,
  output logic      [fgn_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  import fgn_pkg::*;

  // count saturates at FRAME_MAX; the sum at FRAME_MAX full-scale magnitudes
  localparam int CNT_W  = $clog2(FRAME_MAX + 1);
  localparam int SUM_W  = CNT_W + MEAN_W;
  localparam int MCNT_W = $clog2(MUL_N + 1);
  localparam int ACC_W  = 2 * MUL_N;
  localparam logic [SUM_W-1:0] SUM_MAX =
    SUM_W'(FRAME_MAX) * SUM_W'((1 << MEAN_W) - 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,   // waiting for a sample transaction
    S_MUL  = 9'b000000010,   // |sample| * gain, one bit per cycle
    S_CHK  = 9'b000000100,   // clip decision, sum and count update
    S_DIVG = 9'b000001000,   // gain / magnitude after a clip
    S_UPD  = 9'b000010000,   // frame end check
    S_DIVM = 9'b000100000,   // frame mean = sum / count
    S_MULD = 9'b001000000,   // (1 - mean) * rate, serial
    S_GAIN = 9'b010000000,   // apply gain step, clear frame
    S_OUT  = 9'b100000000    // park result in output register
  } state_t;

  state_t state_r, state_nxt;

  // ---- configuration registers ----
  logic [CLIP_W-1:0] clip_r;
  logic [RATE_W-1:0] rate_r;
  reg_idx_t          cfg_idx;

  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r <= CLIP_RST;
      rate_r <= RATE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_CLIP_LIMIT: clip_r <= pwdata[CLIP_W-1:0];
        REG_GAIN_RATE:  rate_r <= pwdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CLIP_LIMIT: prdata = PDATA_W'(clip_r);
      REG_GAIN_RATE:  prdata = PDATA_W'(rate_r);
      default:        prdata = '0;
    endcase
  end

  // ---- kept state ----
  logic [GAIN_W-1:0] gain_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;

  // ---- per-transaction payload ----
  logic                neg_r, last_r, clipped_r, dneg_r;
  logic [SAMPLE_W-1:0] res_r;

  // ---- serial multiplier: acc shifts right, top half takes the partial add
  logic [MUL_N-1:0]  mul_a_r, mul_b_r;
  logic [ACC_W-1:0]  acc_r;
  logic [MCNT_W-1:0] mcnt_r;
  logic [MUL_N:0]    mul_sum;
  logic              mul_last;

  assign mul_sum  = (MUL_N+1)'(acc_r[ACC_W-1:MUL_N])
                  + (MUL_N+1)'(mul_a_r[0] ? mul_b_r : '0);
  assign mul_last = mcnt_r == MCNT_W'(MUL_N - 1);

  // ---- shared divider ----
  logic              div_start, div_busy, div_done;
  logic [MAG_W-1:0]  div_divisor, div_rem0;
  logic [GAIN_W-1:0] div_lo, div_q;

  // ---- datapath terms ----
  logic [SAMPLE_W-1:0] raw, absval;
  logic [MAG_W-1:0]    mag;
  logic                clip_hit, gain_ovf;
  logic [SUM_W:0]      sum_add;
  logic [MEAN_W-1:0]   mean, dmag;
  logic                mean_neg;
  logic [ACC_W-MEAN_W:0] dstep;     // |delta| in Q8.16, rounded away if negative
  logic [GAIN_W:0]     gain_up;
  logic [GAIN_W-1:0]   gain_step;
  logic                in_acc, out_free;

  assign raw      = $unsigned(in_ch.sample_in);
  assign absval   = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - raw) : raw;
  assign mag      = acc_r[MAG_W+15:16];
  assign clip_hit = mag > MAG_W'(clip_r);
  // quotient would not fit 24 bits exactly when gain >= 4 * magnitude
  assign gain_ovf = (MAG_W+2)'(gain_r) >= {mag, 2'b00};
  assign sum_add  = (SUM_W+1)'(sum_r) + (SUM_W+1)'(mag[MEAN_W-1:0]);

  assign mean     = div_q[MEAN_W-1:0];
  assign mean_neg = mean > UNIT_Q22;
  assign dmag     = mean_neg ? (mean - UNIT_Q22) : (UNIT_Q22 - mean);

  assign dstep    = (ACC_W-MEAN_W+1)'(acc_r[ACC_W-1:22])
                  + (ACC_W-MEAN_W+1)'(dneg_r && (acc_r[21:0] != '0));
  assign gain_up  = (GAIN_W+1)'(gain_r) + (GAIN_W+1)'(dstep);

  always_comb begin
    if (dneg_r) begin
      if ((ACC_W-MEAN_W+1)'(gain_r) < dstep) gain_step = GAIN_FLOOR;
      else                                   gain_step = gain_r - GAIN_W'(dstep);
    end else if (gain_up > (GAIN_W+1)'(GAIN_MAX)) begin
      gain_step = GAIN_MAX;
    end else begin
      gain_step = gain_up[GAIN_W-1:0];
    end
  end

  // divider operands: magnitude divide after a clip, else frame mean
  always_comb begin
    if (state_r == S_CHK) begin
      div_divisor = mag;
      div_rem0    = MAG_W'(gain_r[GAIN_W-1:2]);
      div_lo      = {gain_r[1:0], 22'd0};
    end else begin
      div_divisor = MAG_W'(cnt_r);
      div_rem0    = MAG_W'(sum_r[SUM_W-1:GAIN_W]);
      div_lo      = sum_r[GAIN_W-1:0];
    end
  end

  assign div_start = ((state_r == S_CHK) && clip_hit && !gain_ovf)
                  || ((state_r == S_UPD) && last_r);

  fgn_serdiv #(
    .DIV_W (MAG_W),
    .Q_W   (GAIN_W)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .divisor     (div_divisor),
    .rem_init    (div_rem0),
    .dividend_lo (div_lo),
    .busy        (div_busy),
    .done        (div_done),
    .quotient    (div_q)
  );

  // ---- handshakes ----
  assign in_ch.ready = state_r == S_IDLE;
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_MUL;
      S_MUL:  if (mul_last) state_nxt = S_CHK;
      S_CHK:  state_nxt = (clip_hit && !gain_ovf) ? S_DIVG : S_UPD;
      S_DIVG: if (div_done) state_nxt = S_UPD;
      S_UPD:  state_nxt = last_r ? S_DIVM : S_OUT;
      S_DIVM: if (div_done) state_nxt = S_MULD;
      S_MULD: if (mul_last) state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gain_r  <= GAIN_ONE;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHK) begin
        if (cnt_r < CNT_W'(FRAME_MAX)) cnt_r <= cnt_r + CNT_W'(1);
        if (clip_hit) begin
          if (gain_ovf) gain_r <= GAIN_MAX;
        end else if (sum_add > (SUM_W+1)'(SUM_MAX)) begin
          sum_r <= SUM_MAX;
        end else begin
          sum_r <= sum_add[SUM_W-1:0];
        end
      end
      if ((state_r == S_DIVG) && div_done) gain_r <= div_q;
      if (state_r == S_GAIN) begin
        gain_r <= gain_step;
        sum_r  <= '0;
        cnt_r  <= '0;
      end
    end
  end

  // multiplier and per-transaction payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mul_a_r <= absval;
      mul_b_r <= gain_r;
      acc_r   <= '0;
      mcnt_r  <= '0;
      neg_r   <= raw[SAMPLE_W-1];
      last_r  <= in_ch.frame_last;
    end else if ((state_r == S_DIVM) && div_done) begin
      mul_a_r <= MUL_N'(dmag);
      mul_b_r <= MUL_N'(rate_r);
      acc_r   <= '0;
      mcnt_r  <= '0;
      dneg_r  <= mean_neg;
    end else if ((state_r == S_MUL) || (state_r == S_MULD)) begin
      acc_r   <= {mul_sum, acc_r[MUL_N-1:1]};
      mul_a_r <= {1'b0, mul_a_r[MUL_N-1:1]};
      mcnt_r  <= mcnt_r + MCNT_W'(1);
    end
    if (state_r == S_CHK) begin
      clipped_r <= clip_hit;
      if (clip_hit) res_r <= neg_r ? (SAMPLE_W'(0) - SAMPLE_W'(clip_r)) : SAMPLE_W'(clip_r);
      else          res_r <= neg_r ? (SAMPLE_W'(0) - mag[SAMPLE_W-1:0]) : mag[SAMPLE_W-1:0];
    end
  end

  // ---- output register: frees the sequencer while a result waits ----
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_clip_r, out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_sample_r <= res_r;
      out_clip_r   <= clipped_r;
      out_end_r    <= last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = $signed(out_sample_r);
  assign out_ch.was_clipped = out_clip_r;
  assign out_ch.frame_end   = out_end_r;

  // ---- assertions ----
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_MUL)
    else $error("accepted transaction did not start the multiplier");

  a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAME_MAX))
    else $error("sample count above FRAME_MAX");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output state");

endmodule : frame_gain_normalizer_unit
`default_nettype wire

>>> dv/tb_frame_gain_normalizer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_frame_gain_normalizer_unit
// Self-checking bench for the frame gain normaliser. A clocked driver feeds
// sample transactions from a backlog, a clocked monitor compares each result
// with a bit-exact gain/clip/frame-mean predictor, and an APB task moves the
// clip limit and gain rate between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_frame_gain_normalizer_unit;
  import fgn_pkg::*;

  localparam int     FRAME_MAX = FRAME_MAX_DEF;
  localparam longint SUM_CAP   = longint'(FRAME_MAX) * 64'd8388607;
  localparam longint RUN_LIMIT = 8_000_000;   // time units, far beyond a slow run
  localparam int     SETTLE    = 120;         // cycles, above the worst item latency

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
    logic                       frame_end;
  } scaled_t;

  logic clk;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  fgn_in_if  in_ch ();
  fgn_out_if out_ch ();

  frame_gain_normalizer_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Samples waiting to be driven, and results owed by the block, oldest first.
  sample_item_t sample_backlog[$];
  scaled_t      scaled_due[$];
  sample_item_t next_item;
  scaled_t      got_item;

  // Predictor copy of the block's registers and state.
  logic [CLIP_W-1:0] clip_q;
  logic [RATE_W-1:0] rate_q;
  logic [GAIN_W-1:0] gain_q;
  logic [33:0]       sum_q;
  logic [10:0]       count_q;

  int send_idle_pct;
  int recv_idle_pct;
  int n_taken;
  int n_results;
  int n_clipped;
  int n_frames;
  int n_errors;
  int n_count_sat;
  int n_sum_sat;
  int n_gain_top;

  // --------------------------------------------------------------------------
  // Clock, and every block input at a known level from time zero.
  // --------------------------------------------------------------------------
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    in_ch.frame_last = 1'b0;
    out_ch.ready     = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: one sample in, one result out, state advanced as the block
  // would. Magnitude is |x| * gain >> 16; above the limit the output is
  // pinned to +/- limit and the gain is rescaled by limit-free division;
  // otherwise the magnitude joins the frame sum. On the last sample the gain
  // moves by (1 - mean) * rate, floored, with floor and top clamps.
  // --------------------------------------------------------------------------
  function automatic scaled_t scale_sample(logic [SAMPLE_W-1:0] raw, logic last);
    logic [63:0] absval;
    logic [63:0] mag;
    logic [63:0] quot;
    logic [63:0] sum_next;
    logic [63:0] mean;
    longint      prod;
    longint      delta;
    longint      gain_next;
    scaled_t     res;

    absval = raw[SAMPLE_W-1] ? (64'd16777216 - 64'(raw)) : 64'(raw);
    mag    = (absval * 64'(gain_q)) >> 16;
    res.frame_end = last;

    if (mag > 64'(clip_q)) begin
      quot   = (64'(gain_q) << 22) / mag;
      gain_q = (quot > 64'(GAIN_MAX)) ? GAIN_MAX : quot[GAIN_W-1:0];
      if (quot > 64'(GAIN_MAX))
        n_gain_top++;
      res.clipped = 1'b1;
      res.sample  = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - SAMPLE_W'(clip_q)) : SAMPLE_W'(clip_q);
    end else begin
      sum_next = 64'(sum_q) + mag;
      if (sum_next > 64'(SUM_CAP)) begin
        sum_next = 64'(SUM_CAP);
        n_sum_sat++;
      end
      sum_q       = sum_next[33:0];
      res.clipped = 1'b0;
      res.sample  = raw[SAMPLE_W-1] ? (SAMPLE_W'(0) - mag[SAMPLE_W-1:0]) : mag[SAMPLE_W-1:0];
    end

    // count includes clipped samples and sticks at the frame ceiling
    if (count_q < 11'(FRAME_MAX))
      count_q++;
    else
      n_count_sat++;

    if (last) begin
      mean  = 64'(sum_q) / 64'(count_q);
      prod  = (longint'(UNIT_Q22) - longint'(mean)) * longint'(rate_q);
      delta = prod >>> 22;   // floor, also for a negative step
      gain_next = longint'(gain_q) + delta;
      if (gain_next < 0)
        gain_q = GAIN_FLOOR;
      else if (gain_next > longint'(GAIN_MAX)) begin
        gain_q = GAIN_MAX;
        n_gain_top++;
      end else
        gain_q = gain_next[GAIN_W-1:0];
      sum_q   = '0;
      count_q = '0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: predicts on each accepted transaction, then offers the next
  // sample unless the sender is idling this cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scaled_due.push_back(scale_sample(in_ch.sample_in, in_ch.frame_last));
        n_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = sample_backlog.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.sample_in  <= next_item.sample;
          in_ch.frame_last <= next_item.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure; each result against the oldest owed one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (scaled_due.size() == 0) begin
          $error("unexpected result transaction: sample_out %0d", $signed(out_ch.sample_out));
          n_errors++;
        end else begin
          got_item = scaled_due.pop_front();
          if (out_ch.sample_out !== got_item.sample) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(got_item.sample), $signed(out_ch.sample_out));
            n_errors++;
          end
          if (out_ch.was_clipped !== got_item.clipped) begin
            $error("was_clipped: expected %0b, got %0b", got_item.clipped, out_ch.was_clipped);
            n_errors++;
          end
          if (out_ch.frame_end !== got_item.frame_end) begin
            $error("frame_end: expected %0b, got %0b", got_item.frame_end, out_ch.frame_end);
            n_errors++;
          end
          if (got_item.clipped)
            n_clipped++;
          if (got_item.frame_end)
            n_frames++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // APB write: setup cycle, access cycle, register taken on the access edge.
  // --------------------------------------------------------------------------
  task automatic reg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CLIP_LIMIT: clip_q = val[CLIP_W-1:0];
      REG_GAIN_RATE:  rate_q = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the sender until every owed result is back, then let the block settle.
  task automatic drain_block();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || in_ch.valid || scaled_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_sample(int val, bit last);
    sample_item_t it;
    it.sample = SAMPLE_W'(val);
    it.last   = last;
    sample_backlog.push_back(it);
  endtask

  // Mix of full-range noise, tiny values, values around unity and the rails.
  function automatic int pick_sample();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = int'($signed(SAMPLE_W'($urandom)));
      4:          v = $urandom_range(1023);
      5:          v = 4194304 - 512 + $urandom_range(1023);
      6: begin
        case ($urandom_range(4))
          0:       v = 8388607;
          1:       v = -8388608;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default:    v = $urandom_range(6291456);
    endcase
    if ($urandom_range(1) && v > 0)
      v = -v;
    return v;
  endfunction

  // Whole frames with random content; short frames dominate so gain updates
  // come often, with the odd single-sample frame mixed in.
  task automatic queue_frames(int n_items);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 48);
      if (len > left)
        len = left;
      for (int i = 0; i < len; i++)
        push_sample(pick_sample(), i == len - 1);
      left -= len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    clip_q        = CLIP_RST;
    rate_q        = RATE_RST;
    gain_q        = GAIN_ONE;
    sum_q         = '0;
    count_q       = '0;
    send_idle_pct = 19;
    recv_idle_pct = 51;
    n_taken       = 0;
    n_results     = 0;
    n_clipped     = 0;
    n_frames      = 0;
    n_errors      = 0;
    n_count_sat   = 0;
    n_sum_sat     = 0;
    n_gain_top    = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rails and unity at default limit; zero rate leaves the
    // frame-end gain alone while the clip on full scale halves it.
    reg_write(REG_GAIN_RATE, 32'd0);
    @(negedge clk);
    push_sample(0, 1'b0);
    push_sample(8388607, 1'b0);
    push_sample(-8388608, 1'b0);
    push_sample(1, 1'b0);
    push_sample(-1, 1'b0);
    push_sample(4194304, 1'b1);
    drain_block();

    // Tiny clip limit: unity sample forces gain to exactly 1.0, a one-LSB
    // sample then drives the gain to its top, and the frame end tries to
    // push it further. Negative clips come out as zero here.
    reg_write(REG_CLIP_LIMIT, 32'd0);
    reg_write(REG_GAIN_RATE, 32'd8191);
    @(negedge clk);
    push_sample(4194304, 1'b0);
    push_sample(1, 1'b0);
    push_sample(0, 1'b1);
    push_sample(-3, 1'b0);
    push_sample(8388607, 1'b1);
    drain_block();

    // Widest limit: both rails at whatever gain remains.
    reg_write(REG_CLIP_LIMIT, 32'd8388607);
    @(negedge clk);
    push_sample(8388607, 1'b0);
    push_sample(-8388608, 1'b1);
    drain_block();

    // Random, lower end of the working range.
    reg_write(REG_CLIP_LIMIT, 32'd3565158);
    reg_write(REG_GAIN_RATE, 32'd328);
    @(negedge clk);
    queue_frames(200);
    drain_block();

    // Random, upper end; sender now the slow side.
    send_idle_pct = 51;
    recv_idle_pct = 19;
    reg_write(REG_CLIP_LIMIT, 32'd6291456);
    reg_write(REG_GAIN_RATE, 32'd5898);
    @(negedge clk);
    queue_frames(200);
    drain_block();

    // Random settings, no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(REG_CLIP_LIMIT, 32'(3565158 + $urandom_range(6291456 - 3565158)));
    reg_write(REG_GAIN_RATE, 32'($urandom_range(8191)));
    @(negedge clk);
    queue_frames(150);
    drain_block();

    // Long frame: pin gain to 1.0 with a clip, then feed full-scale samples
    // past the frame ceiling so both the count and the sum saturate.
    reg_write(REG_CLIP_LIMIT, 32'd0);
    @(negedge clk);
    push_sample(4194304, 1'b0);
    drain_block();
    reg_write(REG_CLIP_LIMIT, 32'd8388607);
    reg_write(REG_GAIN_RATE, 32'd8191);
    @(negedge clk);
    for (int i = 0; i < FRAME_MAX + 16; i++)
      push_sample(8388607, i == FRAME_MAX + 15);
    drain_block();

    // Back to reset values for a short random tail.
    reg_write(REG_CLIP_LIMIT, 32'(CLIP_RST));
    reg_write(REG_GAIN_RATE, 32'(RATE_RST));
    @(negedge clk);
    queue_frames(50);
    drain_block();

    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d samples in %0d frames, %0d clipped, limit 0 to full scale.",
             n_taken, n_frames, n_clipped);
    $display("Saturation seen: count %0d, sum %0d, gain top %0d; %0d results checked.",
             n_count_sat, n_sum_sat, n_gain_top, n_results);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #(RUN_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule : tb_frame_gain_normalizer_unit
`default_nettype wire
